[design/ospt_pkg.sv]
package ospt_pkg;

  localparam int MAX_CANDIDATES = 8192;
  localparam int IDX_W          = $clog2(MAX_CANDIDATES);
  localparam int CNT_W          = IDX_W + 1;
  localparam int VAL_W          = IDX_W + 1;
  localparam int SUM_W          = CNT_W + 2;
  localparam int KIND_W         = 2;
  localparam int TEST_W         = 32;

  localparam logic [CNT_W-1:0] MIN_CANDIDATES = CNT_W'(4);
  localparam logic [CNT_W-1:0] MAX_CNT        = CNT_W'(MAX_CANDIDATES);
  localparam logic [VAL_W-1:0] FIRST_PRIME    = VAL_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_BUILD = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TEST  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr;
    logic flag_rd;
    logic take;
    logic next_i;
    logic mark;
    logic finish;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic flag_set;
    logic i_zero;
    logic i_last;
    logic j_first_in;
    logic j_next_in;
  } status_t;

endpackage

[design/odd_prime_sieve_table_unit.sv]
// odd-only sieve prime table
//
// input channel (in_valid / in_stall): one beat carries one operation in
// in_kind: build (in_candidate_count), read (in_prime_index) or test
// (in_test_value). result channel (out_valid / out_stall): exactly one beat
// per input beat, in order, with the table's prime count and the answer.
// read and test: the beat is taken while the table and flag memories are
// read, and the result state loads the output register once it is free.
// a build of n candidates (clamped to 4..8192) clears n flags, then
// reads and checks one flag per candidate and marks each odd multiple
// of a prime in turn, then finishes; these steps are serialised by the
// single port of the flag memory.
// one operation is in flight at a time; a new beat is taken as soon as the
// previous result sits in the output register, even if it is still stalled.
// a stalled result holds the output register, and the block waits in its
// result stage until the register frees up.
// synchronous reset empties the table (count zero); memories are not cleared.
module odd_prime_sieve_table_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ospt_pkg::KIND_W-1:0]         in_kind,
  input  logic [ospt_pkg::CNT_W-1:0]          in_candidate_count,
  input  logic [ospt_pkg::IDX_W-1:0]          in_prime_index,
  input  logic signed [ospt_pkg::TEST_W-1:0]  in_test_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ospt_pkg::CNT_W-1:0]          out_prime_count,
  output logic [ospt_pkg::VAL_W-1:0]          out_prime_value,
  output logic                                out_index_valid,
  output logic                                out_is_prime,
  output logic                                out_beyond_table
);
  import ospt_pkg::*;

  cmd_t    cmd;
  status_t sts;
  kind_t   kind_in;

  assign kind_in = kind_t'(in_kind);

  // sequencer: clear, sieve with in-place compaction, result
  ospt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (kind_in),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // flag and table memories, counters and the output register
  ospt_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (kind_in),
    .in_candidate_count (in_candidate_count),
    .in_prime_index     (in_prime_index),
    .in_test_value      (in_test_value),
    .out_prime_count    (out_prime_count),
    .out_prime_value    (out_prime_value),
    .out_index_valid    (out_index_valid),
    .out_is_prime       (out_is_prime),
    .out_beyond_table   (out_beyond_table)
  );

  // a taken beat always leaves the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken but block not busy next cycle");

  // a valid read index always returns a prime, never zero
  a_read_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_valid) |-> (out_prime_value != '0))
    else $error("valid read returned zero");

  // a table hit cannot lie beyond the table
  a_hit_not_beyond: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_prime) |-> !out_beyond_table)
    else $error("membership hit flagged beyond table");

  // a hit needs a built table
  a_hit_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_prime) |-> (out_prime_count != '0))
    else $error("membership hit with empty table");

endmodule

[design/ospt_ctrl.sv]
module ospt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ospt_pkg::kind_t   in_kind,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ospt_pkg::cmd_t    cmd,
  input  ospt_pkg::status_t sts
);
  import ospt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SREAD,
    ST_SCHECK,
    ST_MARK,
    ST_FINISH,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_kind == KIND_BUILD) ? ST_CLEAR : ST_RESULT;
        end
      end
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.i_last) state_nxt = ST_SREAD;
      end
      ST_SREAD: begin
        cmd.flag_rd = 1'b1;
        state_nxt   = ST_SCHECK;
      end
      ST_SCHECK: begin
        cmd.take = 1'b1;
        if (!sts.flag_set && !sts.i_zero && sts.j_first_in) begin
          state_nxt = ST_MARK;
        end else if (sts.i_last) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.next_i = 1'b1;
          state_nxt  = ST_SREAD;
        end
      end
      ST_MARK: begin
        cmd.mark = 1'b1;
        if (!sts.j_next_in) begin
          if (sts.i_last) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.next_i = 1'b1;
            state_nxt  = ST_SREAD;
          end
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[design/ospt_datapath.sv]
module ospt_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ospt_pkg::cmd_t                      cmd,
  output ospt_pkg::status_t                   sts,
  input  ospt_pkg::kind_t                     in_kind,
  input  logic [ospt_pkg::CNT_W-1:0]          in_candidate_count,
  input  logic [ospt_pkg::IDX_W-1:0]          in_prime_index,
  input  logic signed [ospt_pkg::TEST_W-1:0]  in_test_value,
  output logic [ospt_pkg::CNT_W-1:0]          out_prime_count,
  output logic [ospt_pkg::VAL_W-1:0]          out_prime_value,
  output logic                                out_index_valid,
  output logic                                out_is_prime,
  output logic                                out_beyond_table
);
  import ospt_pkg::*;

  logic                     flags_mem [MAX_CANDIDATES];
  logic [VAL_W-1:0]         table_mem [MAX_CANDIDATES];

  kind_t                    kind_r;
  logic [CNT_W-1:0]         n_r, i_r, pos_r, count_r, built_r;
  logic [SUM_W-1:0]         j_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [TEST_W-1:0] tv_r;
  logic [VAL_W-1:0]         last_r;
  logic                     flag_rd_r;
  logic [VAL_W-1:0]         tab_rd_r;

  logic [CNT_W-1:0]         out_count_r;
  logic [VAL_W-1:0]         out_value_r;
  logic                     out_idx_ok_r, out_isp_r, out_beyond_r;

  logic [CNT_W-1:0]         n_clamp;
  logic [VAL_W-1:0]         step, cand_val;
  logic [SUM_W-1:0]         first_sum, next_sum;
  logic                     i_last;
  logic [IDX_W-1:0]         flag_addr;
  logic                     flag_we, flag_re, tab_we;
  logic [TEST_W-3:0]        tv_half;
  logic                     odd_ok, is_two, gt_last, idx_ok;
  logic [VAL_W-1:0]         res_value;
  logic                     res_idx_ok, res_isp, res_beyond;

  always_comb begin
    if (in_candidate_count < MIN_CANDIDATES) n_clamp = MIN_CANDIDATES;
    else if (in_candidate_count > MAX_CNT)   n_clamp = MAX_CNT;
    else                                     n_clamp = in_candidate_count;
  end

  // odd candidate i stands for 2i+1, candidate zero for two
  assign step      = {i_r[IDX_W-1:0], 1'b1};
  assign cand_val  = (i_r == '0) ? FIRST_PRIME : step;
  assign first_sum = SUM_W'(i_r) + SUM_W'(step);
  assign next_sum  = j_r + SUM_W'(step);
  assign i_last    = (i_r == n_r - CNT_W'(1));

  assign sts.flag_set   = flag_rd_r;
  assign sts.i_zero     = (i_r == '0);
  assign sts.i_last     = i_last;
  assign sts.j_first_in = (first_sum < SUM_W'(n_r));
  assign sts.j_next_in  = (next_sum < SUM_W'(n_r));

  always_comb begin
    if (cmd.load)      flag_addr = in_test_value[IDX_W:1];
    else if (cmd.mark) flag_addr = j_r[IDX_W-1:0];
    else               flag_addr = i_r[IDX_W-1:0];
  end
  assign flag_we = cmd.clr || cmd.mark;
  assign flag_re = cmd.load || cmd.flag_rd;
  assign tab_we  = cmd.take && !flag_rd_r;

  always_ff @(posedge clk) begin
    if (flag_we) flags_mem[flag_addr] <= cmd.mark;
    if (flag_re) flag_rd_r <= flags_mem[flag_addr];
  end

  always_ff @(posedge clk) begin
    if (tab_we)   table_mem[pos_r[IDX_W-1:0]] <= cand_val;
    if (cmd.load) tab_rd_r <= table_mem[in_prime_index];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      n_r    <= n_clamp;
      idx_r  <= in_prime_index;
      tv_r   <= in_test_value;
      i_r    <= '0;
      pos_r  <= '0;
    end
    if (cmd.clr) i_r <= i_last ? '0 : i_r + CNT_W'(1);
    if (cmd.next_i) i_r <= i_r + CNT_W'(1);
    if (tab_we) begin
      pos_r  <= pos_r + CNT_W'(1);
      last_r <= cand_val;
    end
    if (cmd.take) j_r <= first_sum;
    if (cmd.mark) j_r <= next_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      built_r <= '0;
    end else if (cmd.finish) begin
      count_r <= pos_r;
      built_r <= n_r;
    end
  end

  // membership comes from the sieve flags left by the last build
  assign tv_half = tv_r[TEST_W-2:1];
  assign odd_ok  = !tv_r[TEST_W-1] && tv_r[0] && (tv_half != '0) &&
                   (tv_half < (TEST_W-2)'(built_r));
  assign is_two  = (tv_r == TEST_W'(FIRST_PRIME));
  assign gt_last = tv_r > $signed({{(TEST_W-VAL_W){1'b0}}, last_r});
  assign idx_ok  = (CNT_W'(idx_r) < count_r);

  always_comb begin
    res_value  = '0;
    res_idx_ok = 1'b0;
    res_isp    = 1'b0;
    res_beyond = 1'b0;
    unique case (kind_r)
      KIND_READ: begin
        res_idx_ok = idx_ok;
        res_value  = idx_ok ? tab_rd_r : '0;
      end
      KIND_TEST: begin
        res_isp    = (count_r != '0) && (is_two || (odd_ok && !flag_rd_r));
        res_beyond = (count_r == '0) || gt_last;
      end
      KIND_BUILD, KIND_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r  <= count_r;
      out_value_r  <= res_value;
      out_idx_ok_r <= res_idx_ok;
      out_isp_r    <= res_isp;
      out_beyond_r <= res_beyond;
    end
  end

  assign out_prime_count  = out_count_r;
  assign out_prime_value  = out_value_r;
  assign out_index_valid  = out_idx_ok_r;
  assign out_is_prime     = out_isp_r;
  assign out_beyond_table = out_beyond_r;

endmodule

[sim/odd_prime_sieve_table_unit_tb.sv]
module odd_prime_sieve_table_unit_tb;
  import ospt_pkg::*;

  // one operation as offered on the input channel
  typedef struct {
    kind_t                    kind;
    logic [CNT_W-1:0]         count;
    logic [IDX_W-1:0]         index;
    logic signed [TEST_W-1:0] value;
    bit                       drain;   // wait for every result before offering
    bit                       steady;  // offer with no gap
  } sieve_op_t;

  // one result beat as the table should answer it
  typedef struct {
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
    bit               valid;
    bit               isp;
    bit               beyond;
  } sieve_answer_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [KIND_W-1:0]        in_kind = '0;
  logic [CNT_W-1:0]         in_candidate_count = '0;
  logic [IDX_W-1:0]         in_prime_index = '0;
  logic signed [TEST_W-1:0] in_test_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CNT_W-1:0]         out_prime_count;
  logic [VAL_W-1:0]         out_prime_value;
  logic                     out_index_valid;
  logic                     out_is_prime;
  logic                     out_beyond_table;

  odd_prime_sieve_table_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_candidate_count (in_candidate_count),
    .in_prime_index     (in_prime_index),
    .in_test_value      (in_test_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_prime_count    (out_prime_count),
    .out_prime_value    (out_prime_value),
    .out_index_valid    (out_index_valid),
    .out_is_prime       (out_is_prime),
    .out_beyond_table   (out_beyond_table)
  );

  always #5 clk = ~clk;

  // shadow of the sieve state, updated as beats are taken
  bit composite [MAX_CANDIDATES];
  int table_primes [MAX_CANDIDATES];
  int table_size = 0;

  sieve_op_t     op_backlog [$];       // ops not yet offered
  sieve_answer_t pending_answers [$];  // answers for taken beats, oldest first
  sieve_op_t     offered;              // op currently on the input ports

  int     beats_taken = 0;
  int     beats_returned = 0;
  int     mismatches = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  int     rand_made = 0;
  bit     in_random_part = 1'b0;
  longint work_budget = 0;
  longint cycle_limit = 64'd100000000;
  longint cycles = 0;

  // candidate count as the block clamps it
  function automatic int clamp_count(int n);
    if (n < int'(MIN_CANDIDATES)) return int'(MIN_CANDIDATES);
    if (n > MAX_CANDIDATES) return MAX_CANDIDATES;
    return n;
  endfunction

  // odd-only sieve: index 0 stands for 2, index i for 2i+1
  function automatic void sieve_rebuild(int n);
    int i;
    int j;
    int step;
    for (i = 0; i < n; i++) composite[i] = 1'b0;
    for (i = 1; i < n; i++) begin
      if (!composite[i]) begin
        step = 2 * i + 1;
        // first mark lands on three times the candidate
        for (j = i + step; j < n; j += step) composite[j] = 1'b1;
      end
    end
    table_size = 0;
    for (i = 0; i < n; i++) begin
      if (!composite[i]) begin
        table_primes[table_size] = (i == 0) ? 2 : 2 * i + 1;
        table_size++;
      end
    end
  endfunction

  // apply one op to the shadow table and work out its result beat
  function automatic sieve_answer_t sieve_answer_for(sieve_op_t op);
    sieve_answer_t a;
    int k;
    a = '{count: '0, value: '0, valid: 1'b0, isp: 1'b0, beyond: 1'b0};
    case (op.kind)
      KIND_BUILD: begin
        sieve_rebuild(clamp_count(int'(op.count)));
      end
      KIND_READ: begin
        // out of range index gives zero and no valid flag
        if (int'(op.index) < table_size) begin
          a.value = VAL_W'(table_primes[op.index]);
          a.valid = 1'b1;
        end
      end
      KIND_TEST: begin
        // empty table leaves beyond set for any value
        a.beyond = 1'b1;
        for (k = 0; k < table_size; k++) begin
          if (op.value == table_primes[k]) begin
            a.isp = 1'b1;
            a.beyond = 1'b0;
            break;
          end
          if (op.value < table_primes[k]) begin
            a.beyond = 1'b0;
            break;
          end
        end
      end
      default: begin
        // unused kind leaves the table alone
      end
    endcase
    a.count = CNT_W'(table_size);
    return a;
  endfunction

  task automatic note_mismatch(string msg);
    $display("tb: mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("beat %0d %s got %0h want %0h", beats_returned, name, got,
                              want));
    end
  endtask

  // queue one op and add its worst case cycles to the run budget
  task automatic queue_op(kind_t k, int cnt, int idx, int val);
    sieve_op_t op;
    op.kind   = k;
    op.count  = CNT_W'(cnt);
    op.index  = IDX_W'(idx);
    op.value  = val;
    op.drain  = in_random_part && (rand_made == 0 || rand_made == 300 || rand_made == 550);
    op.steady = in_random_part && rand_made >= 150 && rand_made < 260;
    op_backlog.push_back(op);
    if (in_random_part) rand_made++;
    // a build walks clear, check and mark passes over the candidates
    if (k == KIND_BUILD) work_budget += 8 * clamp_count(int'(op.count)) + 40;
    else work_budget += 8;
  endtask

  // mostly small builds, a few up to and past the maximum
  function automatic int pick_build_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(3);
    if (r < 88) return $urandom_range(200, 4);
    if (r < 97) return $urandom_range(2048, 201);
    return $urandom_range(16383, 2049);
  endfunction

  // input driver: offers ops from the backlog, holds a stalled beat
  always @(posedge clk) begin : drive_ops
    bit took;
    bit go;
    sieve_op_t nxt;
    took = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (took) begin
        pending_answers.push_back(sieve_answer_for(offered));
        beats_taken <= beats_taken + 1;
      end
      if (!in_valid || took) begin
        go = 1'b0;
        if (op_backlog.size() != 0) begin
          nxt = op_backlog[0];
          go = nxt.steady || ($urandom_range(99) >= 30);
          // pause point: nothing may be in flight
          if (nxt.drain && (took || beats_taken != beats_returned)) go = 1'b0;
        end
        if (go) begin
          void'(op_backlog.pop_front());
          offered            <= nxt;
          in_kind            <= nxt.kind;
          in_candidate_count <= nxt.count;
          in_prime_index     <= nxt.index;
          in_test_value      <= nxt.value;
        end
        in_valid <= go;
      end
    end
  end

  // long receiver hold-off once a good part of the run is through
  always @(posedge clk) begin : receiver_hold
    if (rst_n && !hold_done && beats_returned >= 420) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: checks each taken result beat against the oldest answer
  always @(posedge clk) begin : watch_results
    sieve_answer_t want;
    bit quiet;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          note_mismatch($sformatf("result beat %0d with nothing outstanding",
                                  beats_returned));
        end else begin
          want = pending_answers.pop_front();
          check_field("prime_count", 32'(out_prime_count), 32'(want.count));
          check_field("prime_value", 32'(out_prime_value), 32'(want.value));
          check_field("index_valid", 32'(out_index_valid), 32'(want.valid));
          check_field("is_prime", 32'(out_is_prime), 32'(want.isp));
          check_field("beyond_table", 32'(out_beyond_table), 32'(want.beyond));
        end
        beats_returned <= beats_returned + 1;
      end
      // stretch of results taken with no stall at all
      quiet = beats_returned >= 200 && beats_returned < 300;
      out_stall <= (hold_left != 0) || (!quiet && $urandom_range(99) < 30);
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= cycle_limit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : run
    int n;
    int nc;
    int reps;
    int r;
    int total_ops;

    // empty table, out of range reads, unused kind
    queue_op(KIND_TEST, 0, 0, 5);
    queue_op(KIND_TEST, 0, 0, 32'h8000_0000);
    queue_op(KIND_READ, 0, 0, 0);
    queue_op(KIND_NONE, 16383, 8191, -1);
    // count below the minimum, then reads around the table end
    queue_op(KIND_BUILD, 3, 0, 0);
    queue_op(KIND_READ, 0, 0, 0);
    queue_op(KIND_READ, 0, 4, 0);
    queue_op(KIND_READ, 0, 8191, 0);
    // hit, above the top, below two and the signed maximum
    queue_op(KIND_TEST, 0, 0, 7);
    queue_op(KIND_TEST, 0, 0, 8);
    queue_op(KIND_TEST, 0, 0, 1);
    queue_op(KIND_TEST, 0, 0, -1);
    queue_op(KIND_TEST, 0, 0, 32'h7fff_ffff);
    // count above the maximum: full table
    queue_op(KIND_BUILD, 16383, 0, 0);
    queue_op(KIND_READ, 0, 1899, 0);
    queue_op(KIND_READ, 0, 1900, 0);
    queue_op(KIND_TEST, 0, 0, 16381);
    queue_op(KIND_TEST, 0, 0, 16383);
    queue_op(KIND_TEST, 0, 0, 15);
    queue_op(KIND_TEST, 0, 0, 0);
    queue_op(KIND_BUILD, MAX_CANDIDATES, 0, 0);
    queue_op(KIND_TEST, 0, 0, 2);
    queue_op(KIND_BUILD, 4, 0, 0);
    queue_op(KIND_READ, 0, 3, 0);
    queue_op(KIND_BUILD, 0, 0, 0);

    // random part: build followed by queries aimed at the new table,
    // mixed with fully random beats
    in_random_part = 1'b1;
    while (rand_made < 600) begin
      if ($urandom_range(99) < 15) begin
        r = $urandom_range(3);
        queue_op(kind_t'(r), (r == 0) ? pick_build_count() : $urandom_range(16383),
                 $urandom_range(8191), $urandom());
      end else begin
        n = pick_build_count();
        nc = clamp_count(n);
        queue_op(KIND_BUILD, n, $urandom_range(8191), $urandom());
        reps = $urandom_range(14, 3);
        repeat (reps) begin
          if ($urandom_range(1)) begin
            queue_op(KIND_READ, $urandom_range(16383), $urandom_range(nc / 2 + 2),
                     $urandom());
          end else begin
            r = $urandom_range(99);
            if (r < 55) n = 2 * $urandom_range(nc) + 1;
            else if (r < 65) n = 2;
            else if (r < 80) n = $urandom_range(2 * nc + 8);
            else if (r < 90) n = -int'($urandom_range(100000, 1));
            else n = $urandom();
            queue_op(KIND_TEST, $urandom_range(16383), $urandom_range(8191), n);
          end
        end
      end
    end
    total_ops = op_backlog.size();
    // stalls on both sides and the hold-off at most double the pace
    cycle_limit = 4 * work_budget + 50000;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_taken != total_ops) @(posedge clk);
    while (beats_taken != beats_returned) @(posedge clk);
    // room for any stray beat after the last one
    repeat (20) @(posedge clk);
    if (pending_answers.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
